>>> src/qcs_pkg.sv
package qcs_pkg;

  localparam int COUNT_W    = 32;
  localparam int REG_W      = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = COUNT_W + REG_W;      // |delta| * rpm_scale
  localparam int DIVIDEND_W = PROD_W + FRAC_BITS;   // shifted into Q48.8
  localparam int DIVISOR_W  = REG_W;

  // item operation codes
  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PULSES_PER_REV = 2'd0;
  localparam logic [1:0] REG_RPM_SCALE      = 2'd1;

  localparam logic [REG_W-1:0] PULSES_PER_REV_RST = 16'd205;
  localparam logic [REG_W-1:0] RPM_SCALE_RST      = 16'd600;

  localparam logic [COUNT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COUNT_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

>>> src/qcs_ram.sv
module qcs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 3
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/qcs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module qcs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [qcs_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [qcs_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             busy,
  output logic                             done,
  output logic [qcs_pkg::DIVIDEND_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(qcs_pkg::DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(qcs_pkg::DIVIDEND_W - 1);

  logic [qcs_pkg::DIVISOR_W-1:0] rem;
  logic [qcs_pkg::DIVISOR_W-1:0] dsr;
  logic [CNT_W-1:0]              cnt;
  logic [qcs_pkg::DIVISOR_W:0]   trial;
  logic                          fits;

  assign trial = {rem, quotient[qcs_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
      cnt      <= '0;
    end else if (busy) begin
      quotient <= {quotient[qcs_pkg::DIVIDEND_W-2:0], fits};
      rem      <= fits ? qcs_pkg::DIVISOR_W'(trial - {1'b0, dsr})
                       : qcs_pkg::DIVISOR_W'(trial);
      cnt      <= cnt + 1'b1;
    end
  end

endmodule

>>> src/quadrature_count_and_speed_core.sv
// Quadrature pulse counter and speed meter for CHANNELS motors. Counts and the
// counts saved at the last tick sit in one RAM word per motor, read the cycle
// after the address is given and written back after the update. An edge word
// passes through the edge state; a clear-motor word is done in the idle state.
// A tick visits every motor in turn and returns one result word per motor:
// read, multiply, divider start, a wait on the bit-serial divider (56 steps)
// that forms delta*rpm_scale*256/pulses_per_rev, and the output state, plus any
// wait on out_ready. A new input word is taken only when the previous one is
// finished; the last result may still wait in the output register.
// Configuration writes are always taken.
module quadrature_count_and_speed_core #(
  parameter int CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [1:0]  motor,
  input  logic        level_a,
  input  logic        level_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  channel,
  output logic signed [31:0] pulse_count,
  output logic signed [31:0] speed_q8,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int CW = qcs_pkg::COUNT_W;
  localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGE, ST_TREAD, ST_TMUL, ST_TDIV, ST_TWAIT, ST_TOUT
  } state_t;

  state_t                         state;
  logic [AW-1:0]                  cur;
  logic                           step_up;
  logic [CHANNELS-1:0]            entry_valid;
  logic [qcs_pkg::REG_W-1:0]      pulses_per_rev;
  logic [qcs_pkg::REG_W-1:0]      rpm_scale;
  logic [CW-1:0]                  cnt_r;
  logic [CW-1:0]                  mag_r;
  logic                           neg_r;
  logic [qcs_pkg::PROD_W-1:0]     prod_r;

  logic                           in_take;
  logic                           motor_ok;
  logic [AW-1:0]                  motor_idx;
  logic                           ram_we;
  logic [AW-1:0]                  ram_raddr;
  logic [2*CW-1:0]                ram_wdata;
  logic [2*CW-1:0]                ram_rdata;
  logic [CW-1:0]                  rd_count;
  logic [CW-1:0]                  rd_saved;
  logic [CW-1:0]                  delta;
  logic                           out_free;
  logic                           div_start;
  logic                           div_busy;
  logic                           div_done;
  logic [qcs_pkg::DIVIDEND_W-1:0] div_quot;
  logic [qcs_pkg::DIVISOR_W-1:0]  divisor;
  logic [CW-1:0]                  speed_next;

  assign in_ready  = state == ST_IDLE;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign motor_ok  = int'(motor) < CHANNELS;
  assign motor_idx = AW'(motor);
  assign out_free  = !out_valid || out_ready;

  // never-written or cleared entries read as zero
  assign rd_count = entry_valid[cur] ? ram_rdata[2*CW-1:CW] : '0;
  assign rd_saved = entry_valid[cur] ? ram_rdata[CW-1:0]    : '0;
  assign delta    = rd_count - rd_saved;

  always_comb begin
    ram_raddr = cur;
    if (state == ST_IDLE) begin
      ram_raddr = (operation == qcs_pkg::OP_TICK) ? '0 : motor_idx;
    end else if (state == ST_TOUT) begin
      ram_raddr = cur + 1'b1;
    end
  end

  assign ram_we    = state == ST_EDGE || state == ST_TREAD;
  assign ram_wdata = (state == ST_EDGE)
                     ? {rd_count + (step_up ? 32'd1 : 32'hFFFF_FFFF), rd_saved}
                     : {rd_count, rd_count};

  qcs_ram #(
    .WIDTH (2 * CW),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign div_start = state == ST_TDIV;
  assign divisor   = (pulses_per_rev == '0) ? 16'd1 : pulses_per_rev;

  qcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({prod_r, {qcs_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // saturate to signed 32 bits; negative side allows exactly 2^31
  always_comb begin
    if (!neg_r) begin
      speed_next = (|div_quot[qcs_pkg::DIVIDEND_W-1:CW-1]) ? qcs_pkg::SAT_POS
                                                           : div_quot[CW-1:0];
    end else if ((|div_quot[qcs_pkg::DIVIDEND_W-1:CW]) ||
                 (div_quot[CW-1] && (|div_quot[CW-2:0]))) begin
      speed_next = qcs_pkg::SAT_NEG;
    end else begin
      speed_next = -div_quot[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_rev <= qcs_pkg::PULSES_PER_REV_RST;
      rpm_scale      <= qcs_pkg::RPM_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qcs_pkg::REG_PULSES_PER_REV: pulses_per_rev <= cfg_data;
        qcs_pkg::REG_RPM_SCALE:      rpm_scale      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur         <= '0;
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(state == ST_TOUT && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            case (operation)
              qcs_pkg::OP_EDGE: begin
                if (motor_ok) begin
                  cur   <= motor_idx;
                  state <= ST_EDGE;
                end
              end
              qcs_pkg::OP_TICK: begin
                cur   <= '0;
                state <= ST_TREAD;
              end
              qcs_pkg::OP_CLEAR: begin
                if (motor_ok) begin
                  entry_valid[motor_idx] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_EDGE: begin
          entry_valid[cur] <= 1'b1;
          state            <= ST_IDLE;
        end
        ST_TREAD: begin
          entry_valid[cur] <= 1'b1;
          state            <= ST_TMUL;
        end
        ST_TMUL: begin
          state <= ST_TDIV;
        end
        ST_TDIV: begin
          state <= ST_TWAIT;
        end
        ST_TWAIT: begin
          if (div_done) begin
            state <= ST_TOUT;
          end
        end
        ST_TOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (cur == LAST_CH) begin
              state <= ST_IDLE;
            end else begin
              cur   <= cur + 1'b1;
              state <= ST_TREAD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      step_up <= level_a ^ level_b;
    end
    if (state == ST_TREAD) begin
      cnt_r <= rd_count;
      neg_r <= delta[CW-1];
      mag_r <= delta[CW-1] ? -delta : delta;
    end
    if (state == ST_TMUL) begin
      prod_r <= qcs_pkg::PROD_W'(mag_r) * qcs_pkg::PROD_W'(rpm_scale);
    end
    if (state == ST_TOUT && out_free) begin
      channel     <= 2'(cur);
      pulse_count <= cnt_r;
      speed_q8    <= speed_next;
      last_of_run <= cur == LAST_CH;
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_busy)
    else $error("divider busy while taking input");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_TWAIT)
    else $error("divider finished outside wait state");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> channel == 2'(CHANNELS - 1))
    else $error("last result not on final channel");

  a_tick_ends_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_TOUT && out_free && cur == LAST_CH |=> in_ready)
    else $error("tick did not return to idle after final channel");

endmodule

>>> tb/tb_quadrature_count_and_speed_core.sv
`timescale 1ns / 1ps

module tb_quadrature_count_and_speed_core;

  localparam int CHANNELS       = 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 20;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    logic [1:0]  chan;
    logic [31:0] count;
    logic [31:0] speed;
    logic        last;
  } rpm_word_t;

  class qcs_scoreboard;
    logic [31:0] counts [CHANNELS];
    logic [31:0] saved [CHANNELS];
    logic [31:0] speeds [CHANNELS];
    logic [15:0] ppr;
    logic [15:0] scale;
    rpm_word_t   rpm_words[$];
    int          fails;

    function new();
      for (int k = 0; k < CHANNELS; k++) begin
        counts[k] = '0;
        saved[k]  = '0;
        speeds[k] = '0;
      end
      ppr   = qcs_pkg::PULSES_PER_REV_RST;
      scale = qcs_pkg::RPM_SCALE_RST;
      fails = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        qcs_pkg::REG_PULSES_PER_REV: ppr = data;
        qcs_pkg::REG_RPM_SCALE:      scale = data;
        default: ;
      endcase
    endfunction

    // delta*scale*256/ppr, truncated toward zero, saturated to 32 bits
    function logic [31:0] rpm_q8(logic [31:0] delta);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] div;
      logic [63:0] q;
      neg = delta[31];
      mag = neg ? {32'd0, ~delta + 32'd1} : {32'd0, delta};
      div = (ppr == 16'd0) ? 64'd1 : {48'd0, ppr};
      q   = (mag * {48'd0, scale} * 64'd256) / div;
      if (!neg)
        return (q > {32'd0, qcs_pkg::SAT_POS}) ? qcs_pkg::SAT_POS : q[31:0];
      if (q > {32'd0, qcs_pkg::SAT_NEG})
        q = {32'd0, qcs_pkg::SAT_NEG};
      return ~q[31:0] + 32'd1;
    endfunction

    function void note_word(logic [1:0] op, logic [1:0] m, logic a, logic b);
      rpm_word_t   w;
      logic [31:0] delta;
      case (op)
        qcs_pkg::OP_EDGE: if (m < CHANNELS)
          counts[m] = counts[m] + ((a != b) ? 32'd1 : 32'hFFFF_FFFF);
        qcs_pkg::OP_CLEAR: if (m < CHANNELS) begin
          counts[m] = '0;
          saved[m]  = '0;
        end
        qcs_pkg::OP_TICK: for (int k = 0; k < CHANNELS; k++) begin
          delta     = counts[k] - saved[k];
          saved[k]  = counts[k];
          speeds[k] = rpm_q8(delta);
          w.chan    = 2'(k);
          w.count   = counts[k];
          w.speed   = speeds[k];
          w.last    = (k == CHANNELS - 1);
          rpm_words.push_back(w);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] chan, logic [31:0] cnt, logic [31:0] spd,
                               logic last);
      rpm_word_t w;
      if (rpm_words.size() == 0) begin
        $error("result word with none expected: channel %0d", chan);
        fails++;
        return;
      end
      w = rpm_words.pop_front();
      if (chan !== w.chan) begin
        $error("channel: expected %0d, got %0d", w.chan, chan);
        fails++;
      end
      if (cnt !== w.count) begin
        $error("pulse_count: expected %0d, got %0d", $signed(w.count), $signed(cnt));
        fails++;
      end
      if (spd !== w.speed) begin
        $error("speed_q8: expected %0d, got %0d", $signed(w.speed), $signed(spd));
        fails++;
      end
      if (last !== w.last) begin
        $error("last_of_run: expected %0d, got %0d", w.last, last);
        fails++;
      end
    endfunction

    function int pending();
      return rpm_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = qcs_pkg::OP_EDGE;
  logic [1:0]         motor = 2'd0;
  logic               level_a = 1'b0;
  logic               level_b = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         channel;
  logic signed [31:0] pulse_count;
  logic signed [31:0] speed_q8;
  logic               last_of_run;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = qcs_pkg::REG_PULSES_PER_REV;
  logic [15:0]        cfg_data = '0;

  qcs_scoreboard sb;
  int            burst_left = 0;
  int            hold_reqs = 0;
  int            holds_done = 0;
  int            hold_left = 0;
  int            ready_run = 0;
  int            idle_cycles = 0;
  logic          dir_up [CHANNELS];

  quadrature_count_and_speed_core #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .motor(motor),
    .level_a(level_a),
    .level_b(level_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .channel(channel),
    .pulse_count(pulse_count),
    .speed_q8(speed_q8),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random ready runs, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_reqs != holds_done) begin
      holds_done = holds_done + 1;
      hold_left  = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (ready_run == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        ready_run  = $urandom_range(1, 30);
        out_ready <= 1'b1;
      end else begin
        ready_run  = $urandom_range(1, 8);
        out_ready <= 1'b0;
      end
    end else begin
      ready_run = ready_run - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(channel, pulse_count, speed_q8, last_of_run);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic [1:0] op, logic [1:0] m, logic a, logic b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid  <= 1'b1;
    operation <= op;
    motor     <= m;
    level_a   <= a;
    level_b   <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, m, a, b);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  // no word in flight: all results back, plus time for a trailing edge word
  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] ppr, logic [15:0] scale);
    wait_idle();
    write_reg(qcs_pkg::REG_PULSES_PER_REV, ppr);
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    write_reg(qcs_pkg::REG_RPM_SCALE, scale);
    cfg_valid <= 1'b0;
  endtask

  task automatic edge_run(logic [1:0] m, logic up, int len);
    logic a;
    repeat (len) begin
      a = 1'($urandom_range(0, 1));
      send_word(qcs_pkg::OP_EDGE, m, a, up ? ~a : a);
    end
  endtask

  // mostly drifting edge runs with ticks between them; some clears and noise;
  // a closing tick shows the counts under the current setup
  task automatic traffic(int n_words);
    int         sent;
    int         r;
    logic [1:0] m;
    logic       a;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m = 2'($urandom_range(0, CHANNELS - 1));
        a = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
          send_word(qcs_pkg::OP_EDGE, m, a, 1'($urandom_range(0, 1)));
        else
          send_word(qcs_pkg::OP_EDGE, m, a, dir_up[m] ? ~a : a);
        sent++;
      end else if (r < 85) begin
        send_word(qcs_pkg::OP_TICK, 2'($urandom), 1'($urandom), 1'($urandom));
        for (int k = 0; k < CHANNELS; k++)
          dir_up[k] = 1'($urandom_range(0, 1));
        sent++;
      end else if (r < 91) begin
        send_word(qcs_pkg::OP_CLEAR, 2'($urandom_range(0, 3)), 1'($urandom),
                  1'($urandom));
        sent++;
      end else if (r < 95) begin
        send_word(OP_UNUSED, 2'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_word($urandom_range(0, 1) ? qcs_pkg::OP_EDGE : qcs_pkg::OP_CLEAR, 2'd3,
                  1'($urandom), 1'($urandom));
      end
    end
    send_word(qcs_pkg::OP_TICK, 2'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [1:0] m_up;
    logic [1:0] m_dn;
    sb = new();
    for (int k = 0; k < CHANNELS; k++)
      dir_up[k] = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every level pair, every op, ignored motor and op, clear
    send_word(qcs_pkg::OP_EDGE, 2'd0, 1'b0, 1'b0);
    send_word(qcs_pkg::OP_EDGE, 2'd0, 1'b0, 1'b1);
    send_word(qcs_pkg::OP_EDGE, 2'd0, 1'b1, 1'b0);
    send_word(qcs_pkg::OP_EDGE, 2'd0, 1'b1, 1'b1);
    send_word(qcs_pkg::OP_EDGE, 2'd0, 1'b1, 1'b0);
    send_word(qcs_pkg::OP_EDGE, 2'd1, 1'b1, 1'b1);
    send_word(qcs_pkg::OP_EDGE, 2'd1, 1'b0, 1'b0);
    send_word(qcs_pkg::OP_EDGE, 2'd2, 1'b0, 1'b1);
    send_word(qcs_pkg::OP_EDGE, 2'd3, 1'b1, 1'b0);
    send_word(OP_UNUSED, 2'd3, 1'b1, 1'b1);
    send_word(OP_UNUSED, 2'd0, 1'b0, 1'b0);
    send_word(qcs_pkg::OP_TICK, 2'd0, 1'b0, 1'b0);
    send_word(qcs_pkg::OP_CLEAR, 2'd1, 1'b0, 1'b0);
    send_word(qcs_pkg::OP_CLEAR, 2'd3, 1'b1, 1'b1);
    send_word(qcs_pkg::OP_TICK, 2'd3, 1'b1, 1'b1);
    send_word(qcs_pkg::OP_EDGE, 2'd2, 1'b1, 1'b1);
    send_word(qcs_pkg::OP_EDGE, 2'd0, 1'b0, 1'b1);
    send_word(qcs_pkg::OP_TICK, 2'd2, 1'b0, 1'b1);

    // highest gain: runs of 129+ saturate both ways; receiver holds off meanwhile
    set_config(16'd1, 16'hFFFF);
    hold_reqs = hold_reqs + 1;
    send_word(qcs_pkg::OP_TICK, 2'd0, 1'b0, 1'b0);
    m_up = 2'($urandom_range(0, CHANNELS - 1));
    m_dn = 2'((m_up + 1) % CHANNELS);
    edge_run(m_up, 1'b1, $urandom_range(129, 134));
    edge_run(m_dn, 1'b0, $urandom_range(129, 134));
    send_word(qcs_pkg::OP_TICK, 2'd1, 1'b1, 1'b0);
    traffic(10);

    set_config(16'hFFFF, 16'd1);
    traffic(10);
    set_config(16'd0, 16'd0);
    traffic(8);
    set_config(16'd0, 16'd60000);
    traffic(8);
    set_config(qcs_pkg::PULSES_PER_REV_RST, qcs_pkg::RPM_SCALE_RST);
    traffic(10);
    set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 60000)));
    traffic(12);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
